FILE: rtl/keyframe_linear_sampler_assert.svh
// Assertion macros for the keyframe linear sampler RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef KEYFRAME_LINEAR_SAMPLER_ASSERT_SVH
`define KEYFRAME_LINEAR_SAMPLER_ASSERT_SVH
// Checks that a condition implies another in the same cycle.
`define KLS_ASSERT_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Checks that a condition implies another in the next cycle.
`define KLS_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

FILE: rtl/kls_pkg.sv
// Package of the keyframe linear sampler: widths, request codes, control structs.
// Depends on nothing.
`default_nettype none
package kls_pkg;
   localparam int MaxKeys = 64;
   localparam int AddrW = $clog2(MaxKeys);
   localparam int CountW = $clog2(MaxKeys + 1);
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              wr_key;
      logic [AddrW-1:0]  wr_addr;
      logic              rd_en;
      logic [AddrW-1:0]  rd_addr;
      logic              ld_query;
      logic              cap_lo;
      logic              cap_hi;
      logic              div_start;
      logic              mul_start;
      logic [1:0]        mul_sel;
      logic              ld_first;
      logic              ld_lo;
      logic              ld_zero;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic le_first;
      logic in_pair;
      logic div_done;
      logic mul_done;
   } stat_type;
endpackage
`default_nettype wire

FILE: rtl/kls_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`default_nettype none
interface kls_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        restart_table;
   logic [31:0] key_time;
   logic signed [31:0] key_x;
   logic signed [31:0] key_y;
   logic signed [31:0] key_z;
   logic [31:0] sample_time;
   modport source(output valid, req_type, restart_table, key_time, key_x, key_y,
      key_z, sample_time, input ready);
   modport sink(input valid, req_type, restart_table, key_time, key_x, key_y,
      key_z, sample_time, output ready);
endinterface

interface kls_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic        status;
   modport source(output valid, out_x, out_y, out_z, status, input ready);
   modport sink(input valid, out_x, out_y, out_z, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/kls_datapath.sv
// Datapath: key memories, bracket compare, serial divider, serial multiplier.
// Depends on kls_pkg.
`default_nettype none
module kls_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kls_pkg::cmd_type cmd,
   output kls_pkg::stat_type     stat,
   input  wire logic [31:0]      key_time,
   input  wire logic [31:0]      key_x,
   input  wire logic [31:0]      key_y,
   input  wire logic [31:0]      key_z,
   input  wire logic [31:0]      sample_time,
   output logic [31:0]           res_x,
   output logic [31:0]           res_y,
   output logic [31:0]           res_z
);
   logic [31:0] mem_t [kls_pkg::MaxKeys];
   logic [31:0] mem_x [kls_pkg::MaxKeys];
   logic [31:0] mem_y [kls_pkg::MaxKeys];
   logic [31:0] mem_z [kls_pkg::MaxKeys];
   logic [31:0] rd_t_ff, rd_x_ff, rd_y_ff, rd_z_ff;
   logic [31:0] t0_ff, a_x_ff, a_y_ff, a_z_ff;
   logic [31:0] r_x_ff, r_y_ff, r_z_ff;
   logic [31:0] qt_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.wr_key) begin
         mem_t[cmd.wr_addr] <= key_time;
         mem_x[cmd.wr_addr] <= key_x;
         mem_y[cmd.wr_addr] <= key_y;
         mem_z[cmd.wr_addr] <= key_z;
      end
      if (cmd.rd_en) begin
         rd_t_ff <= mem_t[cmd.rd_addr];
         rd_x_ff <= mem_x[cmd.rd_addr];
         rd_y_ff <= mem_y[cmd.rd_addr];
         rd_z_ff <= mem_z[cmd.rd_addr];
      end
   end

   // The query time of the accepted beat, the lower key of the pair under test,
   // and the differences to the upper key.
   logic [32:0] d_x_ff, d_y_ff, d_z_ff;
   always_ff @(posedge clock) begin
      if (cmd.ld_query) qt_ff <= sample_time;
      if (cmd.cap_lo) begin
         t0_ff  <= rd_t_ff;
         a_x_ff <= rd_x_ff;
         a_y_ff <= rd_y_ff;
         a_z_ff <= rd_z_ff;
      end
      if (cmd.cap_hi) begin
         d_x_ff <= {rd_x_ff[31], rd_x_ff} - {a_x_ff[31], a_x_ff};
         d_y_ff <= {rd_y_ff[31], rd_y_ff} - {a_y_ff[31], a_y_ff};
         d_z_ff <= {rd_z_ff[31], rd_z_ff} - {a_z_ff[31], a_z_ff};
      end
   end

   // Bracket tests against the freshly read key.
   assign stat.le_first = (qt_ff <= rd_t_ff);
   assign stat.in_pair = (t0_ff <= qt_ff) && (qt_ff <= rd_t_ff);

   // Restoring divider: frac = (dt << 16) / span, 48 steps; zero span gives 0.
   logic [47:0] num_ff;
   logic [32:0] rem_ff;
   logic [31:0] den_ff;
   logic [5:0]  dcnt_ff;
   logic        dbusy_ff, ddone_ff;
   logic [32:0] rem_sh;
   always_comb rem_sh = {rem_ff[31:0], num_ff[47]};
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.div_start) begin
            num_ff   <= {qt_ff - t0_ff, 16'd0};
            den_ff   <= rd_t_ff - t0_ff;
            rem_ff   <= 33'd0;
            dcnt_ff  <= 6'd0;
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            if (den_ff == 32'd0) begin
               num_ff   <= 48'd0;
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end else begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_ff <= rem_sh - {1'b0, den_ff};
                  num_ff <= {num_ff[46:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[46:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd47) begin
                  dbusy_ff <= 1'b0;
                  ddone_ff <= 1'b1;
               end
            end
         end
      end
   end
   assign stat.div_done = ddone_ff;

   // Multiply of one difference by frac, registered, then floor shift and add.
   logic [16:0] frac;
   assign frac = num_ff[16:0];
   logic signed [32:0] mul_d;
   logic [31:0]        mul_a;
   logic signed [50:0] prod_ff;
   logic [1:0]         msel_ff;
   logic               mv_ff;
   always_comb begin
      case (cmd.mul_sel)
         2'd0:    begin mul_d = d_x_ff; mul_a = a_x_ff; end
         2'd1:    begin mul_d = d_y_ff; mul_a = a_y_ff; end
         default: begin mul_d = d_z_ff; mul_a = a_z_ff; end
      endcase
   end
   logic [31:0] acc_a_ff;
   always_ff @(posedge clock) begin
      if (reset) mv_ff <= 1'b0;
      else mv_ff <= cmd.mul_start;
      prod_ff  <= mul_d * $signed({1'b0, frac});
      msel_ff  <= cmd.mul_sel;
      acc_a_ff <= mul_a;
   end
   assign stat.mul_done = mv_ff;
   logic [31:0] lerp;
   assign lerp = acc_a_ff + prod_ff[47:16];

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.ld_zero) begin
         r_x_ff <= 32'd0; r_y_ff <= 32'd0; r_z_ff <= 32'd0;
      end else if (cmd.ld_first) begin
         r_x_ff <= rd_x_ff; r_y_ff <= rd_y_ff; r_z_ff <= rd_z_ff;
      end else if (cmd.ld_lo) begin
         r_x_ff <= a_x_ff; r_y_ff <= a_y_ff; r_z_ff <= a_z_ff;
      end else if (mv_ff) begin
         case (msel_ff)
            2'd0:    r_x_ff <= lerp;
            2'd1:    r_y_ff <= lerp;
            default: r_z_ff <= lerp;
         endcase
      end
   end
   assign res_x = r_x_ff;
   assign res_y = r_y_ff;
   assign res_z = r_z_ff;
endmodule
`default_nettype wire

FILE: rtl/kls_ctrl.sv
// Controller state machine: appends, scans the key table, sequences the lerp.
// Depends on kls_pkg and the assertion header.
`default_nettype none
`include "keyframe_linear_sampler_assert.svh"
module kls_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic             req_type,
   input  wire logic             restart_table,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic                  out_status,
   output kls_pkg::cmd_type      cmd,
   input  wire kls_pkg::stat_type stat
);
   localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CHK0 = 4'd2,
      S_LO = 4'd3, S_HI = 4'd4, S_TEST = 4'd5, S_DIV = 4'd6, S_MUL = 4'd7,
      S_MWAIT = 4'd8, S_LAST = 4'd9, S_LAST2 = 4'd10, S_OUT = 4'd11,
      S_LASTLD = 4'd12;
   localparam int AW = kls_pkg::AddrW;
   localparam int CW = kls_pkg::CountW;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0]    msel_ff, msel_in;
   logic          status_ff, status_in;
   logic          fire;
   logic [CW-1:0] base;

   assign fire = in_valid && in_ready;
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_status = status_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      msel_in   = msel_ff;
      status_in = status_ff;
      cmd       = '0;
      base      = restart_table ? '0 : count_ff;
      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               if (req_type == kls_pkg::REQ_APPEND) begin
                  if (base < CW'(kls_pkg::MaxKeys)) begin
                     cmd.wr_key  = 1'b1;
                     cmd.wr_addr = base[AW-1:0];
                     count_in    = base + CW'(1);
                  end else begin
                     count_in = base;
                  end
               end else if (count_ff == '0) begin
                  status_in   = 1'b1;
                  cmd.ld_zero = 1'b1;
                  state_in    = S_OUT;
               end else begin
                  status_in    = 1'b0;
                  cmd.ld_query = 1'b1;
                  cmd.rd_en    = 1'b1;
                  cmd.rd_addr  = '0;
                  state_in     = S_RD0;
               end
            end
         end
         S_RD0: state_in = S_CHK0;
         // Entry 0 is in the read register.
         S_CHK0: begin
            if (count_ff == CW'(1) || stat.le_first) begin
               cmd.ld_first = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.cap_lo  = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(1);
               idx_in      = CW'(1);
               state_in    = S_HI;
            end
         end
         S_HI: state_in = S_TEST;
         // Entry idx is in the read register; lower key is idx-1.
         S_TEST: begin
            if (stat.in_pair) begin
               cmd.cap_hi    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (idx_ff + CW'(1) == count_ff) begin
               cmd.cap_lo = 1'b1;
               state_in   = S_LASTLD;
            end else begin
               cmd.cap_lo  = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = AW'(idx_ff + CW'(1));
               idx_in      = idx_ff + CW'(1);
               state_in    = S_HI;
            end
         end
         S_LASTLD: begin
            cmd.ld_lo = 1'b1;
            state_in  = S_OUT;
         end
         S_DIV: begin
            if (stat.div_done) begin
               msel_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = msel_ff;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (msel_ff == 2'd2) state_in = S_OUT;
            else begin
               msel_in  = msel_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         msel_ff   <= 2'd0;
         status_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         msel_ff   <= msel_in;
         status_ff <= status_in;
      end
   end

   `KLS_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(kls_pkg::MaxKeys))
   `KLS_ASSERT_IMPL(a_wr_idle, clock, reset, cmd.wr_key, state_ff == S_IDLE)
   `KLS_ASSERT_NEXT(a_div_done, clock, reset, stat.div_done, state_ff == S_MUL)
   `KLS_ASSERT_IMPL(a_scan_range, clock, reset, state_ff == S_TEST, idx_ff < count_ff)
endmodule
`default_nettype wire

FILE: rtl/keyframe_linear_sampler.sv
// Keyframe linear sampler top level: joins kls_ctrl and kls_datapath to the channels.
// An append is stored at its accepting edge; a sample result is valid in the cycle after
// acceptance on an empty table; otherwise the table is scanned pair by pair, and a
// bracketing pair runs the serial divider and three multiplies before the result.
// Appends are taken one per cycle while idle; after a sample, the next beat is taken only
// once the result beat has left. Synchronous active-high reset empties the table, not memories.
`default_nettype none
module keyframe_linear_sampler (
   input wire logic clock,
   input wire logic reset,
   kls_req_if.sink  req,
   kls_rsp_if.source rsp
);
   kls_pkg::cmd_type  cmd;
   kls_pkg::stat_type stat;
   logic [31:0] rx, ry, rz;

   kls_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .req_type(req.req_type), .restart_table(req.restart_table),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_status(rsp.status),
      .cmd(cmd), .stat(stat)
   );

   kls_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .key_time(req.key_time), .key_x(req.key_x), .key_y(req.key_y),
      .key_z(req.key_z), .sample_time(req.sample_time),
      .res_x(rx), .res_y(ry), .res_z(rz)
   );

   assign rsp.out_x = rx;
   assign rsp.out_y = ry;
   assign rsp.out_z = rz;
endmodule
`default_nettype wire

FILE: test/kls_tb_if.sv
// Testbench-side notes for the sampler's channel interfaces.
// Depends on nothing; kls_req_if and kls_rsp_if are defined in rtl/kls_if.sv.
`timescale 1ns / 1ps
// The channel interfaces are reused from the RTL; this file only fixes the
// beat records that the driver queue and the expected-sample queue carry.
package kls_tb_pkg;
   typedef struct {
      logic        req_type;
      logic        restart_table;
      logic [31:0] key_time;
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [31:0] sample_time;
   } req_beat_type;

   typedef struct {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic        status;
   } rsp_beat_type;
endpackage

FILE: test/tb_top.sv
// Testbench of keyframe_linear_sampler: random and directed appends and samples,
// checked against an in-bench keyframe table predictor.
// Depends on kls_pkg, kls_if.sv and kls_tb_pkg.
`timescale 1ns / 1ps
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;

   kls_req_if req ();
   kls_rsp_if rsp ();

   keyframe_linear_sampler DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   kls_tb_pkg::req_beat_type pending_beats[$];
   kls_tb_pkg::rsp_beat_type expected_samples[$];
   int        error_count = 0;
   int        hold_cycles = 0;
   int        rsp_gap = 0;
   int        req_gap = 0;
   bit        req_taken = 1'b0;

   // Predictor copy of the keyframe table.
   logic [31:0] tbl_time[kls_pkg::MaxKeys];
   logic [31:0] tbl_x[kls_pkg::MaxKeys];
   logic [31:0] tbl_y[kls_pkg::MaxKeys];
   logic [31:0] tbl_z[kls_pkg::MaxKeys];
   int          tbl_count = 0;

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Appends one beat to the driver's pending queue.
   task automatic queue_beat(kls_tb_pkg::req_beat_type b);
      pending_beats = {pending_beats, b};
   endtask

   // Linear blend of one component; the product is exact in 64 bits.
   function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                         longint unsigned frac);
      longint va;
      longint vb;
      longint prod;
      va = longint'($signed(a));
      vb = longint'($signed(b));
      prod = (vb - va) * longint'(frac);
      // Arithmetic shift floors toward minus infinity.
      return 32'(va + (prod >>> 16));
   endfunction

   // Applies one accepted beat to the table and queues any sample it yields.
   task automatic predict_beat(kls_tb_pkg::req_beat_type b);
      kls_tb_pkg::rsp_beat_type r;
      longint unsigned frac;
      logic [31:0]     span;
      bit              found;
      if (b.req_type == kls_pkg::REQ_APPEND) begin
         if (b.restart_table) tbl_count = 0;
         if (tbl_count < kls_pkg::MaxKeys) begin
            tbl_time[tbl_count] = b.key_time;
            tbl_x[tbl_count] = b.key_x;
            tbl_y[tbl_count] = b.key_y;
            tbl_z[tbl_count] = b.key_z;
            tbl_count++;
         end
         return;
      end
      r.status = 1'b0;
      found = 1'b0;
      if (tbl_count == 0) begin
         r = '{32'd0, 32'd0, 32'd0, 1'b1};
      end else if (tbl_count == 1 || b.sample_time <= tbl_time[0]) begin
         r.out_x = tbl_x[0];
         r.out_y = tbl_y[0];
         r.out_z = tbl_z[0];
      end else begin
         for (int i = 0; i + 1 < tbl_count && !found; i++) begin
            if (tbl_time[i] <= b.sample_time && b.sample_time <= tbl_time[i+1]) begin
               span = tbl_time[i+1] - tbl_time[i];
               frac = 0;
               if (span != 0)
                  frac = (longint'(b.sample_time - tbl_time[i]) << 16) / longint'(span);
               r.out_x = blend(tbl_x[i], tbl_x[i+1], frac);
               r.out_y = blend(tbl_y[i], tbl_y[i+1], frac);
               r.out_z = blend(tbl_z[i], tbl_z[i+1], frac);
               found = 1'b1;
            end
         end
         if (!found) begin
            r.out_x = tbl_x[tbl_count-1];
            r.out_y = tbl_y[tbl_count-1];
            r.out_z = tbl_z[tbl_count-1];
         end
      end
      expected_samples = {expected_samples, r};
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: presents beats from the queue at the falling edge. A beat is held
   // until the monitor has seen it taken at a rising edge.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req.valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            kls_tb_pkg::req_beat_type b;
            b = pending_beats.pop_front();
            req.valid <= 1'b1;
            req.req_type <= b.req_type;
            req.restart_table <= b.restart_table;
            req.key_time <= b.key_time;
            req.key_x <= b.key_x;
            req.key_y <= b.key_y;
            req.key_z <= b.key_z;
            req.sample_time <= b.sample_time;
            req_gap = random_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure at the falling edge; a long hold is counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap = random_gap();
      end
   end

   // Monitor: predicts on input beats and checks result beats at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            kls_tb_pkg::req_beat_type b;
            b = '{req.req_type, req.restart_table, req.key_time, req.key_x,
                  req.key_y, req.key_z, req.sample_time};
            predict_beat(b);
            req_taken = 1'b1;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               report("unexpected result beat", rsp.out_x, 32'd0);
            end else begin
               kls_tb_pkg::rsp_beat_type e;
               e = expected_samples.pop_front();
               if (rsp.out_x !== e.out_x) report("out_x", rsp.out_x, e.out_x);
               if (rsp.out_y !== e.out_y) report("out_y", rsp.out_y, e.out_y);
               if (rsp.out_z !== e.out_z) report("out_z", rsp.out_z, e.out_z);
               if (rsp.status !== e.status)
                  report("status", {31'd0, rsp.status}, {31'd0, e.status});
            end
         end
      end
   end

   function automatic kls_tb_pkg::req_beat_type make_append(bit restart, logic [31:0] t,
                                             logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
      return '{kls_pkg::REQ_APPEND, restart, t, x, y, z, $urandom()};
   endfunction

   function automatic kls_tb_pkg::req_beat_type make_sample(logic [31:0] t);
      return '{kls_pkg::REQ_SAMPLE, 1'($urandom()), $urandom(), $urandom(), $urandom(),
               $urandom(), t};
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         default: return $urandom();
      endcase
   endfunction

   // Waits until the queue drains and every sample has returned.
   task automatic wait_drained();
      while (pending_beats.size() > 0 || req.valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Builds one animation track: times ascend with occasional ties, then samples.
   task automatic queue_track(int keys, int samples);
      logic [31:0] t;
      logic [31:0] t_last;
      int          step_max;
      step_max = $urandom_range(0, 1) ? 32'h0004_0000 : 32'h0fff_ffff;
      t = $urandom_range(0, 32'h0010_0000);
      for (int k = 0; k < keys; k++) begin
         queue_beat(make_append(k == 0, t, rand_value(), rand_value(), rand_value()));
         t_last = t;
         if ($urandom_range(0, 7) != 0) t = t + $urandom_range(1, step_max);
      end
      for (int s = 0; s < samples; s++) begin
         case ($urandom_range(0, 5))
            0: queue_beat(make_sample($urandom_range(0, t_last + 2)));
            1: queue_beat(make_sample($urandom()));
            default: queue_beat(make_sample($urandom_range(0, t_last)));
         endcase
      end
   endtask

   initial begin
      int issued;
      req.valid = 1'b0;
      req.req_type = kls_pkg::REQ_APPEND;
      req.restart_table = 1'b0;
      req.key_time = '0;
      req.key_x = '0;
      req.key_y = '0;
      req.key_z = '0;
      req.sample_time = '0;
      rsp.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, single key, extremes, zero-length span, overflow.
      queue_beat(make_sample(32'h0));
      queue_beat(make_append(1'b0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
      queue_beat(make_sample(32'hffff_ffff));
      queue_beat(make_append(1'b0, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff,
                             32'hffff_ffff));
      queue_beat(make_append(1'b0, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h1234_5678));
      queue_beat(make_append(1'b0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0));
      queue_beat(make_sample(32'h0));
      queue_beat(make_sample(32'h0001_0000));
      queue_beat(make_sample(32'h0002_0000));
      queue_beat(make_sample(32'h0002_ffff));
      queue_beat(make_sample(32'h0003_0000));
      queue_beat(make_sample(32'hffff_fffe));
      queue_beat(make_sample(32'hffff_ffff));
      // Out-of-order key, then overflow of the table.
      queue_beat(make_append(1'b1, 32'h0005_0000, 32'h10, 32'h20, 32'h30));
      queue_beat(make_append(1'b0, 32'h0002_0000, 32'h40, 32'h50, 32'h60));
      queue_beat(make_sample(32'h0004_0000));
      for (int k = 0; k < kls_pkg::MaxKeys + 2; k++)
         queue_beat(make_append(k == 0, k << 16, k, -k, k << 20));
      queue_beat(make_sample(32'hffff_ffff));
      queue_beat(make_sample(32'h0020_8000));

      // Long receiver stall while the sender keeps offering samples.
      hold_cycles = 600;
      for (int s = 0; s < 6; s++) queue_beat(make_sample($urandom()));
      while (hold_cycles > 0) @(posedge clock);
      wait_drained();

      // Random tracks: mostly short, an occasional full table.
      issued = 0;
      while (issued < 700) begin
         int keys;
         int samples;
         keys = ($urandom_range(0, 15) == 0) ? $urandom_range(40, kls_pkg::MaxKeys + 3)
                                              : $urandom_range(1, 8);
         samples = $urandom_range(2, 8);
         if ($urandom_range(0, 9) == 0) begin
            // Noise: an isolated sample between tracks.
            queue_beat(make_sample($urandom()));
            issued++;
         end
         queue_track(keys, samples);
         issued += keys + samples;
         while (pending_beats.size() > 20) @(posedge clock);
         if ($urandom_range(0, 19) == 0) wait_drained();
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_samples.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // Run limit well above the slowest correct run.
   initial begin
      #40_000_000;
      $display("tb_top: errors");
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/kls_pkg.sv
rtl/kls_if.sv
rtl/kls_datapath.sv
rtl/kls_ctrl.sv
rtl/keyframe_linear_sampler.sv
test/kls_tb_if.sv
test/tb_top.sv
